[hdl/srl_pkg.sv]
// ----------------------------------------------------------------------------
// srl_pkg - shared types and constants of the S-record loader parser
// Parse phases, result kinds, character codes and the result record.
// ----------------------------------------------------------------------------
package srl_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] SUM_GOOD = 8'hFF;
    localparam logic [7:0] HDR_BYTES = 8'd3;

    localparam logic [3:0] TYPE_HDR   = 4'd0;
    localparam logic [3:0] TYPE_DATA  = 4'd1;
    localparam logic [3:0] TYPE_START = 4'd9;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_TYPE  = 4'd1,
        PH_LEN_H = 4'd2,
        PH_LEN_L = 4'd3,
        PH_AH_H  = 4'd4,
        PH_AH_L  = 4'd5,
        PH_AL_H  = 4'd6,
        PH_AL_L  = 4'd7,
        PH_DAT_H = 4'd8,
        PH_DAT_L = 4'd9,
        PH_CK_H  = 4'd10,
        PH_CK_L  = 4'd11,
        PH_EOL   = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        K_MEM    = 3'd0,
        K_HDR    = 3'd1,
        K_START  = 3'd2,
        K_OK     = 3'd3,
        K_CKERR  = 3'd4,
        K_BADTYP = 3'd5,
        K_BADHEX = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  address;
        logic [BYTE_W-1:0]  value;
    } t_result;

endpackage

[hdl/srecord_loader_parser.sv]
// ----------------------------------------------------------------------------
// srecord_loader_parser - S-record (S0/S1/S9) character stream loader
// Decode S-record lines one character per transaction into memory writes,
// header characters, start address, record status and error reports.
// ----------------------------------------------------------------------------
// Feed the file one ASCII character per transaction on the slave side. Each
// character is captured in an input register, parsed by a single pass of
// the line parser against the held state once the output register has
// room, and any result is registered there, so a character can enter on
// every clock while results are taken. The parser gives at most one
// result per character: a memory write for every S1 data byte (address
// counts up and wraps at 16 bits), a header byte for every S0 data byte,
// the start address when an S9 address is complete, and a record-ok report
// carrying the type digit once a checksum matches. A bad type digit, a
// non-hex character where a digit is due, or a failing checksum reports the
// error and then halts the parser; after that all characters are consumed
// and dropped until reset. Backpressure on the master side stalls the input
// register and, through it, the slave side.
// ----------------------------------------------------------------------------
module srecord_loader_parser
    import srl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] address, [23:16] value
    output logic [2:0]  o_m_tuser    // [2:0] kind
);

    logic        r_in_vld;
    logic [7:0]  r_in_ch;
    logic        r_m_vld;
    logic [23:0] r_m_tdata;
    logic [2:0]  r_m_tuser;

    logic        out_free;
    logic        step;
    logic        res_vld;
    t_result     res;

    // output register can take a result this cycle
    assign out_free   = !r_m_vld || i_m_tready;
    // parse the held character once there is room for its result
    assign step       = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;

    srl_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_ch      (r_in_ch),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // input register: advance whenever the slave side is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
    end

    // output register: load on a step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (step) begin
            r_m_vld <= res_vld;
        end else if (i_m_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_vld) begin
            r_m_tdata <= {res.value, res.address};
            r_m_tuser <= res.kind;
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

[hdl/srl_hex_dec.sv]
// ----------------------------------------------------------------------------
// srl_hex_dec - ASCII hex digit decoder
// Map 0-9, A-F and a-f to a nibble and flag every other character.
// ----------------------------------------------------------------------------
module srl_hex_dec (
    input  logic [7:0] i_ch,
    output logic       o_ok,
    output logic [3:0] o_nib
);

    always_comb begin
        o_ok  = 1'b1;
        o_nib = 4'd0;
        if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_nib = i_ch[3:0];
        end else if ((i_ch >= 8'h41 && i_ch <= 8'h46) || (i_ch >= 8'h61 && i_ch <= 8'h66)) begin
            // letters: low three bits run 1..6 for A..F
            o_nib = 4'd9 + {1'b0, i_ch[2:0]};
        end else begin
            o_ok = 1'b0;
        end
    end

endmodule

[hdl/srl_core.sv]
// ----------------------------------------------------------------------------
// srl_core - S-record line parser
// Hold the parse state and turn one registered character into at most one
// result per step.
// ----------------------------------------------------------------------------
module srl_core
    import srl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_ch,
    output logic        o_res_vld,
    output t_result     o_res
);

    t_phase             r_phase, n_phase;
    logic [3:0]         r_high, n_high;
    logic [3:0]         r_type, n_type;
    logic [7:0]         r_rem, n_rem;
    logic [7:0]         r_sum, n_sum;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_halt, n_halt;

    logic               hex_ok;
    logic [3:0]         nib;
    logic [7:0]         byte_val;
    logic [7:0]         sum_upd;
    logic [7:0]         rem_dec;
    logic               type_ok;

    srl_hex_dec u_hex (
        .i_ch  (i_ch),
        .o_ok  (hex_ok),
        .o_nib (nib)
    );

    assign byte_val = {r_high, nib};
    assign sum_upd  = r_sum + byte_val;
    assign rem_dec  = r_rem - 8'd1;
    assign type_ok  = (i_ch == CH_ZERO) || (i_ch == CH_ONE) || (i_ch == CH_NINE);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_type  = r_type;
        n_rem   = r_rem;
        n_sum   = r_sum;
        n_addr  = r_addr;
        n_halt  = r_halt;
        if (i_step && !r_halt) begin
            unique case (r_phase)
                PH_EOL: begin
                    if (i_ch == CH_LF) n_phase = PH_START;
                end
                PH_TYPE: begin
                    if (!type_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_type  = i_ch[3:0];
                        n_sum   = 8'd0;
                        n_rem   = 8'd0;
                        n_phase = PH_LEN_H;
                    end
                end
                PH_LEN_H, PH_AH_H, PH_AL_H, PH_DAT_H, PH_CK_H: begin
                    if (!hex_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_high  = nib;
                        n_phase = t_phase'(r_phase + 4'd1);
                    end
                end
                PH_LEN_L: begin
                    if (!hex_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_sum   = sum_upd;
                        n_rem   = (byte_val >= HDR_BYTES) ? byte_val - HDR_BYTES : 8'd0;
                        n_phase = PH_AH_H;
                    end
                end
                PH_AH_L: begin
                    if (!hex_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_sum   = sum_upd;
                        n_addr  = {byte_val, 8'd0};
                        n_phase = PH_AL_H;
                    end
                end
                PH_AL_L: begin
                    if (!hex_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_sum   = sum_upd;
                        n_addr  = {r_addr[ADDR_W-1:8], byte_val};
                        n_phase = (r_rem != 8'd0) ? PH_DAT_H : PH_CK_H;
                    end
                end
                PH_DAT_L: begin
                    if (!hex_ok) begin
                        n_halt = 1'b1;
                    end else begin
                        n_sum   = sum_upd;
                        n_rem   = rem_dec;
                        n_phase = (rem_dec != 8'd0) ? PH_DAT_H : PH_CK_H;
                        if (r_type == TYPE_DATA) n_addr = r_addr + 16'd1;
                    end
                end
                PH_CK_L: begin
                    if (!hex_ok || sum_upd != SUM_GOOD) begin
                        n_halt = 1'b1;
                    end else begin
                        n_sum   = sum_upd;
                        n_phase = PH_EOL;
                    end
                end
                default: begin
                    n_phase = (i_ch == CH_LF) ? PH_START : PH_TYPE;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_vld     = 1'b0;
        o_res.kind    = K_OK;
        o_res.address = '0;
        o_res.value   = '0;
        if (i_step && !r_halt) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (!type_ok) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = K_BADTYP;
                    end
                end
                PH_LEN_H, PH_LEN_L, PH_AH_H, PH_AH_L, PH_AL_H,
                PH_DAT_H, PH_CK_H: begin
                    if (!hex_ok) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = K_BADHEX;
                    end
                end
                PH_AL_L: begin
                    if (!hex_ok) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = K_BADHEX;
                    end else if (r_type == TYPE_START) begin
                        o_res_vld     = 1'b1;
                        o_res.kind    = K_START;
                        o_res.address = {r_addr[ADDR_W-1:8], byte_val};
                    end
                end
                PH_DAT_L: begin
                    if (!hex_ok) begin
                        o_res_vld  = 1'b1;
                        o_res.kind = K_BADHEX;
                    end else if (r_type == TYPE_DATA) begin
                        o_res_vld     = 1'b1;
                        o_res.kind    = K_MEM;
                        o_res.address = r_addr;
                        o_res.value   = byte_val;
                    end else if (r_type == TYPE_HDR) begin
                        o_res_vld   = 1'b1;
                        o_res.kind  = K_HDR;
                        o_res.value = byte_val;
                    end
                end
                PH_CK_L: begin
                    o_res_vld = 1'b1;
                    if (!hex_ok) begin
                        o_res.kind = K_BADHEX;
                    end else if (sum_upd != SUM_GOOD) begin
                        o_res.kind = K_CKERR;
                    end else begin
                        o_res.value = {4'd0, r_type};
                    end
                end
                default: begin
                    o_res_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_high  <= 4'd0;
            r_type  <= 4'd0;
            r_rem   <= 8'd0;
            r_sum   <= 8'd0;
            r_addr  <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_type  <= n_type;
            r_rem   <= n_rem;
            r_sum   <= n_sum;
            r_addr  <= n_addr;
            r_halt  <= n_halt;
        end
    end

endmodule

[tb/srecord_loader_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_loader_parser_tb - self-checking bench for the S-record loader
// Feed S0/S1/S9 lines one character per transaction with random content,
// random idling on both stream sides, and one closing fault that halts the
// parser. A line-level decoder inside the scoreboard predicts every result.
// ----------------------------------------------------------------------------
module srecord_loader_parser_tb;
    import srl_pkg::*;

    localparam int unsigned CHAR_BUDGET = 1050;   // characters to send before the closing record
    localparam int unsigned IDLE_LIMIT  = 5000;   // cycles with no transaction
    localparam int unsigned DRAIN_WAIT  = 16;     // settle cycles at the end
    localparam int unsigned MODE_SPAN   = 150;    // characters per idling mode

    // closing fault injected into the last record
    typedef enum int {
        FAULT_NONE,
        FAULT_SUM,
        FAULT_HEX,
        FAULT_TYPE
    } t_fault;

    // ------------------------------------------------------------------------
    // Scoreboard: decode the character stream as the parser should and keep
    // the results that are owed, in order.
    // ------------------------------------------------------------------------
    class srec_scoreboard;
        t_phase      phase;
        logic [3:0]  nibble_hi;
        logic [3:0]  rec_type;
        logic [7:0]  data_left;
        logic [7:0]  running_sum;
        logic [15:0] load_addr;
        bit          halted;
        t_result     pending_results[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            phase        = PH_START;
            nibble_hi    = '0;
            rec_type     = '0;
            data_left    = '0;
            running_sum  = '0;
            load_addr    = '0;
            halted       = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        static function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            return -1;
        endfunction

        function void owe(t_kind k, logic [15:0] a, logic [7:0] v);
            t_result r;
            r.kind    = k;
            r.address = a;
            r.value   = v;
            pending_results.push_back(r);
        endfunction

        // a whole hex pair has arrived: fold it into the sum and act on it
        function void take_byte(logic [7:0] b);
            running_sum = running_sum + b;
            case (phase)
                PH_LEN_L: begin
                    data_left = (b >= HDR_BYTES) ? b - HDR_BYTES : 8'd0;
                    phase     = PH_AH_H;
                end
                PH_AH_L: begin
                    load_addr = {b, 8'h00};
                    phase     = PH_AL_H;
                end
                PH_AL_L: begin
                    load_addr[7:0] = b;
                    phase = (data_left != 0) ? PH_DAT_H : PH_CK_H;
                    if (rec_type == TYPE_START)
                        owe(K_START, load_addr, 8'h00);
                end
                PH_DAT_L: begin
                    data_left = data_left - 8'd1;
                    phase = (data_left != 0) ? PH_DAT_H : PH_CK_H;
                    if (rec_type == TYPE_DATA) begin
                        owe(K_MEM, load_addr, b);
                        load_addr = load_addr + 16'd1;
                    end else if (rec_type == TYPE_HDR) begin
                        owe(K_HDR, 16'h0000, b);
                    end
                end
                default: begin
                    if (running_sum != SUM_GOOD) begin
                        halted = 1'b1;
                        owe(K_CKERR, 16'h0000, 8'h00);
                    end else begin
                        phase = PH_EOL;
                        owe(K_OK, 16'h0000, {4'h0, rec_type});
                    end
                end
            endcase
        endfunction

        // one accepted input character
        function void parse_char(logic [7:0] ch);
            int d;
            if (halted) return;
            if (phase == PH_EOL) begin
                if (ch == CH_LF) phase = PH_START;
                return;
            end
            if (phase == PH_TYPE) begin
                if (ch != CH_ZERO && ch != CH_ONE && ch != CH_NINE) begin
                    halted = 1'b1;
                    owe(K_BADTYP, 16'h0000, 8'h00);
                    return;
                end
                rec_type    = ch[3:0];
                running_sum = '0;
                data_left   = '0;
                phase       = PH_LEN_H;
                return;
            end
            if (phase == PH_START) begin
                phase = (ch == CH_LF) ? PH_START : PH_TYPE;
                return;
            end
            d = digit_value(ch);
            if (d < 0) begin
                halted = 1'b1;
                owe(K_BADHEX, 16'h0000, 8'h00);
                return;
            end
            if (!phase[0]) begin
                nibble_hi = d[3:0];
                phase     = t_phase'(phase + 4'd1);
            end else begin
                take_byte({nibble_hi, d[3:0]});
            end
        endfunction

        // one accepted result, compared against the oldest owed one
        function void check_result(logic [2:0] kind, logic [15:0] addr, logic [7:0] value);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $error("result with none owed: kind %0d address %h value %h",
                       kind, addr, value);
                return;
            end
            want = pending_results.pop_front();
            if (want.kind != kind) begin
                mismatches++;
                $error("kind: expected %0d, actual %0d", want.kind, kind);
            end
            if (want.address != addr) begin
                mismatches++;
                $error("address: expected %h, actual %h", want.address, addr);
            end
            if (want.value != value) begin
                mismatches++;
                $error("value: expected %h, actual %h", want.value, value);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test
    // ------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] ch
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;            // [15:0] address, [23:16] value
    logic [2:0]  o_m_tuser;            // [2:0] kind

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    srecord_loader_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    srec_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_sent         = 0;
    int unsigned idle_cycles    = 0;
    int unsigned n_s0, n_s1, n_s9, n_empty;
    t_fault      closing_fault  = FAULT_NONE;

    logic [7:0]  line_q[$];    // characters of the line being built
    logic [7:0]  payload[$];   // data bytes of the record being built

    // ------------------------------------------------------------------------
    // Master side: stall at random and check every result transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata[15:0], o_m_tdata[23:16]);
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Slave side driving
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_not_lf();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        return c;
    endfunction

    // Send one character; the idling mode rotates every MODE_SPAN characters
    // so that quiet stretches alternate with heavy gaps and stalls.
    task automatic send_char(input logic [7:0] ch);
        case ((n_sent / MODE_SPAN) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        n_sent++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_tready);
        sb.parse_char(ch);
    endtask

    // Append one byte as two hex digits, mixing upper and lower case
    task automatic put_byte(input logic [7:0] b);
        logic [3:0] n;
        for (int i = 1; i >= 0; i--) begin
            n = b[i*4 +: 4];
            if (n < 10)
                line_q.push_back(CH_ZERO + 8'(n));
            else if ($urandom_range(0, 2) == 0)
                line_q.push_back(8'("a") + 8'(n) - 8'd10);
            else
                line_q.push_back(8'("A") + 8'(n) - 8'd10);
        end
    endtask

    // Build one record from payload and send it; a fault corrupts it on purpose
    task automatic send_record(input logic [7:0] lead, input logic [3:0] rtype,
                               input logic [15:0] addr, input logic [7:0] count,
                               input t_fault fault);
        logic [7:0] sum;
        logic [7:0] ck;
        logic [7:0] c;
        int         pos;
        line_q.delete();
        line_q.push_back(lead);
        line_q.push_back(CH_ZERO + 8'(rtype));
        sum = count + addr[15:8] + addr[7:0];
        put_byte(count);
        put_byte(addr[15:8]);
        put_byte(addr[7:0]);
        foreach (payload[i]) begin
            sum = sum + payload[i];
            put_byte(payload[i]);
        end
        ck = ~sum;
        if (fault == FAULT_SUM)
            ck = ck ^ 8'($urandom_range(1, 255));
        put_byte(ck);
        if (fault == FAULT_HEX) begin
            pos = $urandom_range(2, line_q.size() - 1);
            do c = 8'($urandom_range(0, 255)); while (srec_scoreboard::digit_value(c) >= 0);
            line_q[pos] = c;
        end
        if (fault == FAULT_TYPE) begin
            // LF is also a bad type digit
            if ($urandom_range(0, 3) == 0)
                c = CH_LF;
            else
                do c = 8'($urandom_range(0, 255));
                while (c == CH_ZERO || c == CH_ONE || c == CH_NINE);
            line_q[1] = c;
        end
        // trailing junk up to the end of line is ignored
        repeat ($urandom_range(0, 2)) line_q.push_back(random_not_lf());
        line_q.push_back(CH_LF);
        case (rtype)
            TYPE_HDR:  n_s0++;
            TYPE_DATA: n_s1++;
            default:   n_s9++;
        endcase
        foreach (line_q[i]) send_char(line_q[i]);
    endtask

    task automatic fill_payload(input logic [7:0] count);
        payload.delete();
        if (count > HDR_BYTES)
            repeat (count - HDR_BYTES) payload.push_back(8'($urandom_range(0, 255)));
    endtask

    // Random well-formed record: mostly short, now and then a short count
    // or a long one, addresses often close to the wrap point
    task automatic send_random_record(input t_fault fault);
        logic [3:0]  rtype;
        logic [7:0]  count;
        logic [15:0] addr;
        logic [7:0]  lead;
        int          r;
        r = $urandom_range(0, 99);
        rtype = (r < 60) ? TYPE_DATA : (r < 80) ? TYPE_HDR : TYPE_START;
        r = $urandom_range(0, 99);
        if (r < 4)
            count = 8'($urandom_range(0, 2));
        else if (r < 6)
            count = 8'($urandom_range(100, 255));
        else
            count = 8'($urandom_range(3, 12));
        addr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                           : 16'($urandom_range(0, 16'hFFFF));
        lead = ($urandom_range(0, 3) == 0) ? random_not_lf() : 8'("S");
        fill_payload(count);
        send_record(lead, rtype, addr, count, fault);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        n_s0 = 0; n_s1 = 0; n_s9 = 0; n_empty = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty line, header, write across the wrap, short count,
        // start record with a data byte that only feeds the checksum
        send_char(CH_LF);
        n_empty++;
        payload = {8'h48, 8'h69};
        send_record("S", TYPE_HDR, 16'h0000, 8'd5, FAULT_NONE);
        payload = {8'h00, 8'hFF};
        send_record(8'hFF, TYPE_DATA, 16'hFFFF, 8'd5, FAULT_NONE);
        payload.delete();
        send_record(8'h00, TYPE_DATA, 16'h8000, 8'd2, FAULT_NONE);
        payload = {8'hA5};
        send_record("S", TYPE_START, 16'h1234, 8'd4, FAULT_NONE);

        // random: well-formed lines with random content and the odd empty line
        while (n_sent < CHAR_BUDGET) begin
            if ($urandom_range(0, 19) == 0) begin
                send_char(CH_LF);
                n_empty++;
            end else begin
                send_random_record(FAULT_NONE);
            end
        end

        // close on one fault, then check the halted parser drops everything
        closing_fault = t_fault'($urandom_range(FAULT_SUM, FAULT_TYPE));
        send_random_record(closing_fault);
        repeat (20) send_char(8'($urandom_range(0, 255)));
        i_s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d characters: %0d S0, %0d S1, %0d S9 records, %0d empty lines",
                 n_sent, n_s0, n_s1, n_s9, n_empty);
        $display("%0d results compared; closing fault %s halted the parser",
                 sb.results_seen, closing_fault.name());
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
